// ===== rtl/core/b64se_pkg.sv =====
// ----------------------------------------------------------------------------
// b64se_pkg
// shared types, constants and the alphabet lookup of the base64 encoder
// ----------------------------------------------------------------------------
`default_nettype none

package b64se_pkg;

  localparam logic [7:0] CHAR_PAD     = 8'd61;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_PLUS    = 8'd43;
  localparam logic [7:0] CHAR_SLASH   = 8'd47;
  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] OFS_LOWER    = 8'd71;
  localparam logic [7:0] OFS_DIGIT    = 8'd4;
  localparam logic [5:0] SEXT_LOWER   = 6'd26;
  localparam logic [5:0] SEXT_DIGIT   = 6'd52;
  localparam logic [5:0] SEXT_PLUS    = 6'd62;

  localparam logic [3:0] LINE_GROUP_LAST = 4'd15;

  typedef enum logic [1:0] {
    GRP_FULL,
    GRP_ONE,
    GRP_TWO
  } grp_kind_e;

  typedef struct packed {
    logic [23:0] bits;
    grp_kind_e   kind;
    logic        newline;
    logic        last;
  } grp_cmd_t;

  function automatic logic [7:0] b64_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < SEXT_LOWER) begin
      c = CHAR_UPPER_A + {2'b00, s};
    end else if (s < SEXT_DIGIT) begin
      c = OFS_LOWER + {2'b00, s};
    end else if (s < SEXT_PLUS) begin
      c = {2'b00, s} - OFS_DIGIT;
    end else if (s == SEXT_PLUS) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/b64se_if.sv =====
// ----------------------------------------------------------------------------
// b64se interfaces
// valid/ready channels for bytes, characters and the configuration write
// ----------------------------------------------------------------------------
`default_nettype none

interface b64se_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;
  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64se_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;
  modport source (output valid, output out_char, output out_last, input ready);
  modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

interface b64se_cfg_if;
  logic valid;
  logic ready;
  logic line_breaks_on;
  modport source (output valid, output line_breaks_on, input ready);
  modport sink   (input valid, input line_breaks_on, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/b64se_front.sv =====
// ----------------------------------------------------------------------------
// b64se_front
// accepts bytes, gathers groups and issues group commands to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module b64se_front
  import b64se_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  b64se_cfg_if.sink     cfg,
  b64se_byte_if.sink    in,
  input  wire logic     q_full_i,
  output grp_cmd_t      cmd_o,
  output logic          push_o
);

  logic [15:0] pending_q, pending_d;
  logic [1:0]  phase_q, phase_d;
  logic [3:0]  groups_q, groups_d;
  logic        lbo_q;
  logic        accept;

  assign cfg.ready = 1'b1;
  assign in.ready  = !q_full_i;
  assign accept    = in.valid && in.ready;

  always_comb begin
    pending_d     = pending_q;
    phase_d       = phase_q;
    groups_d      = groups_q;
    push_o        = 1'b0;
    cmd_o.bits    = {pending_q, in.data_byte};
    cmd_o.kind    = GRP_FULL;
    cmd_o.newline = 1'b0;
    cmd_o.last    = in.final_byte;
    if (accept) begin
      if (phase_q == 2'd2) begin
        push_o        = 1'b1;
        cmd_o.newline = lbo_q && (groups_q == LINE_GROUP_LAST);
        groups_d      = groups_q + 4'd1;
        pending_d     = '0;
        phase_d       = 2'd0;
      end else if (!in.final_byte) begin
        pending_d = {pending_q[7:0], in.data_byte};
        phase_d   = (phase_q == 2'd1) ? 2'd2 : 2'd1;
      end else if (phase_q == 2'd1) begin
        push_o     = 1'b1;
        cmd_o.bits = {pending_q[7:0], in.data_byte, 8'd0};
        cmd_o.kind = GRP_TWO;
      end else begin
        push_o     = 1'b1;
        cmd_o.bits = {in.data_byte, 16'd0};
        cmd_o.kind = GRP_ONE;
      end
      if (in.final_byte) begin
        pending_d = '0;
        phase_d   = 2'd0;
        groups_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      phase_q   <= '0;
      groups_q  <= '0;
      lbo_q     <= 1'b0;
    end else begin
      pending_q <= pending_d;
      phase_q   <= phase_d;
      groups_q  <= groups_d;
      if (cfg.valid) begin
        lbo_q <= cfg.line_breaks_on;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/b64se_queue.sv =====
// ----------------------------------------------------------------------------
// b64se_queue
// short fifo of group commands between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module b64se_queue
  import b64se_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire grp_cmd_t cmd_i,
  input  wire logic     pop_i,
  output grp_cmd_t      cmd_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] PtrLast = AW'(Depth - 1);
  localparam logic [CW-1:0] CntFull = CW'(Depth);

  grp_cmd_t        mem_q [Depth];
  logic [AW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("queue count out of range");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("queue count missed a push");

endmodule

`default_nettype wire

// ===== rtl/core/b64se_back.sv =====
// ----------------------------------------------------------------------------
// b64se_back
// turns group commands into characters, one per cycle unless stalled, into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module b64se_back
  import b64se_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire grp_cmd_t cmd_i,
  input  wire logic     empty_i,
  output logic          pop_o,
  b64se_char_if.source  out
);

  grp_cmd_t   cmd_q;
  logic       busy_q, busy_d;
  logic [2:0] idx_q, idx_d;
  logic       out_valid_q;
  logic [7:0] out_char_q;
  logic       out_last_q;
  logic [2:0] idx_end;
  logic       at_end, adv, emit, load;
  logic [7:0] ch;

  assign idx_end = cmd_q.newline ? 3'd4 : 3'd3;
  assign at_end  = (idx_q == idx_end);
  assign adv     = !out_valid_q || out.ready;
  assign emit    = busy_q && adv;
  assign load    = (!busy_q || (emit && at_end)) && !empty_i;
  assign pop_o   = load;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (emit) begin
      busy_d = !at_end;
      idx_d  = idx_q + 3'd1;
    end
  end

  always_comb begin
    case (idx_q)
      3'd0: ch = b64_char(cmd_q.bits[23:18]);
      3'd1: ch = b64_char(cmd_q.bits[17:12]);
      3'd2: ch = (cmd_q.kind == GRP_ONE) ? CHAR_PAD : b64_char(cmd_q.bits[11:6]);
      3'd3: ch = (cmd_q.kind == GRP_FULL) ? b64_char(cmd_q.bits[5:0]) : CHAR_PAD;
      default: ch = CHAR_NEWLINE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= cmd_i;
    end
    if (emit) begin
      out_char_q <= ch;
      out_last_q <= cmd_q.last && at_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out.valid    = out_valid_q;
  assign out.out_char = out_char_q;
  assign out.out_last = out_last_q;

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= idx_end))
    else $error("character index past group end");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!busy_q || at_end))
    else $error("new group loaded over an unfinished one");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("emitted character not presented");

endmodule

`default_nettype wire

// ===== rtl/core/base64_stream_encoder_top.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// streaming base64 encoder, standard alphabet with '=' padding
// ----------------------------------------------------------------------------
// usage:
//   in_i  : one message byte per transaction, final_byte set on the last byte
//   out_o : one character per transaction, out_last set on the final character
//   cfg_i : writes line_breaks_on; write only while the encoder is idle
// every third byte yields four characters, plus a newline after each 16th full
// group when line breaks are on; a final partial group yields four characters
// ending in "=" or "==".
// the first character of a completed group passes through the queue, the command
// register and the output register. throughput: one character per cycle while
// out_o is ready and groups are queued, set by the single output register.
// the group queue holds QueueDepth commands, so bytes keep being accepted
// while the receiver stalls until the queue fills; then in_i.ready drops.
// reset clears the held bytes, group count, queue and line_breaks_on.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder_top
  import b64se_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  b64se_cfg_if.sink     cfg_i,
  b64se_byte_if.sink    in_i,
  b64se_char_if.source  out_o
);

  grp_cmd_t push_cmd, head_cmd;
  logic     push, pop, q_full, q_empty;

  b64se_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg      (cfg_i),
    .in       (in_i),
    .q_full_i (q_full),
    .cmd_o    (push_cmd),
    .push_o   (push)
  );

  b64se_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  b64se_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (head_cmd),
    .empty_i (q_empty),
    .pop_o   (pop),
    .out     (out_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_b64se_char_sb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_b64se_char_sb_pkg
// Predicts the character stream of the base64 stream encoder from the bytes
// it accepts. Expected characters are queued and compared in order with each
// character that leaves the block, so mismatches are counted as they occur.
// ----------------------------------------------------------------------------

package tb_b64se_char_sb_pkg;

  import b64se_pkg::CHAR_PAD;
  import b64se_pkg::CHAR_NEWLINE;

  localparam logic [0:63][7:0] B64_ALPHABET = {
    "ABCDEFGHIJKLMNOP", "QRSTUVWXYZabcdef", "ghijklmnopqrstuv", "wxyz0123456789+/"
  };

  typedef struct packed {
    logic [7:0] chr;
    logic       last;
  } enc_char_t;

  class b64_char_scoreboard;
    enc_char_t   expected_chars[$];
    logic        breaks_on;
    logic [15:0] held_bytes;
    logic [1:0]  held_count;
    logic [3:0]  groups_in_line;
    int unsigned errors;
    int unsigned bytes_seen;
    int unsigned messages_seen;
    int unsigned chars_checked;
    int unsigned newlines_due;
    int unsigned padded_groups;

    function new();
      breaks_on      = 1'b0;
      held_bytes     = '0;
      held_count     = '0;
      groups_in_line = '0;
      errors         = 0;
      bytes_seen     = 0;
      messages_seen  = 0;
      chars_checked  = 0;
      newlines_due   = 0;
      padded_groups  = 0;
    endfunction

    function void set_breaks(input logic on);
      breaks_on = on;
    endfunction

    function automatic logic [7:0] sextet_char(input logic [23:0] grp, input int shift);
      logic [5:0] s;
      s = grp[shift +: 6];
      return B64_ALPHABET[s];
    endfunction

    function void note_byte(input logic [7:0] b, input logic fin);
      logic [7:0]  chars[5];
      logic [23:0] grp;
      int          n;
      enc_char_t   e;
      n = 0;
      bytes_seen++;
      if (held_count == 2'd2) begin
        grp = {held_bytes, b};
        chars[0] = sextet_char(grp, 18);
        chars[1] = sextet_char(grp, 12);
        chars[2] = sextet_char(grp, 6);
        chars[3] = sextet_char(grp, 0);
        n = 4;
        if (breaks_on && groups_in_line == 4'd15) begin
          chars[4] = CHAR_NEWLINE;
          n = 5;
          newlines_due++;
        end
        groups_in_line = groups_in_line + 4'd1;
        held_bytes = '0;
        held_count = '0;
      end else if (!fin) begin
        held_bytes = {held_bytes[7:0], b};
        held_count = held_count + 2'd1;
        return;
      end else if (held_count == 2'd0) begin
        grp = {b, 16'h0000};
        chars[0] = sextet_char(grp, 18);
        chars[1] = sextet_char(grp, 12);
        chars[2] = CHAR_PAD;
        chars[3] = CHAR_PAD;
        n = 4;
        padded_groups++;
      end else begin
        grp = {held_bytes[7:0], b, 8'h00};
        chars[0] = sextet_char(grp, 18);
        chars[1] = sextet_char(grp, 12);
        chars[2] = sextet_char(grp, 6);
        chars[3] = CHAR_PAD;
        n = 4;
        padded_groups++;
      end
      for (int i = 0; i < n; i++) begin
        e.chr  = chars[i];
        e.last = fin && (i == n - 1);
        expected_chars.push_back(e);
      end
      if (fin) begin
        messages_seen++;
        held_bytes     = '0;
        held_count     = '0;
        groups_in_line = '0;
      end
    endfunction

    task report(input string what);
      errors++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_char(input logic [7:0] c, input logic last);
      enc_char_t e;
      chars_checked++;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected character 0x%02h last %0b", c, last));
        return;
      end
      e = expected_chars.pop_front();
      if (c !== e.chr) begin
        report($sformatf("character 0x%02h, expected 0x%02h", c, e.chr));
      end
      if (last !== e.last) begin
        report($sformatf("last flag %0b on 0x%02h, expected %0b", last, c, e.last));
      end
    endtask
  endclass

endpackage

// ===== tb/tb_base64_stream_encoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder_top
// directed and random messages, line breaks off and on, sender gaps, receiver
// stalls and one long receiver hold-off, every character checked in order
// ----------------------------------------------------------------------------

module tb_base64_stream_encoder_top;

  import tb_b64se_char_sb_pkg::*;

  logic clk_i;
  logic rst_ni;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles = 0;

  b64_char_scoreboard sb;

  b64se_cfg_if  cfg_if ();
  b64se_byte_if in_if ();
  b64se_char_if out_if ();

  base64_stream_encoder_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever begin
      #10 clk_i = ~clk_i;
    end
  end

  initial begin
    #5ms;
    $display("tb_base64_stream_encoder_top failed");
    $finish;
  end

  // receiver ready, with a counted hold-off for backpressure
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_char(out_if.out_char, out_if.out_last);
    end
  end

  task automatic write_breaks(input logic on);
    cfg_if.valid          = 1'b1;
    cfg_if.line_breaks_on = on;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_breaks(on);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      = 1'b1;
    in_if.data_byte  = b;
    in_if.final_byte = fin;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_byte(b, fin);
    @(negedge clk_i);
  endtask

  task automatic send_packed(input logic [63:0] bytes, input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(bytes[8*(len-1-i) +: 8], i == len - 1);
    end
  endtask

  task automatic send_random_msg(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom), i == len - 1);
    end
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (sb.expected_chars.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_phase(input logic on, input int unsigned idle_pct,
                           input int unsigned stall_pct, input int first_len,
                           input int item_target);
    int sent;
    int len;
    int r;
    sent = 0;
    len  = first_len;
    write_breaks(on);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < item_target) begin
      if (len == 0) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          len = 48;
        end else if (r == 1) begin
          len = $urandom_range(49, 70);
        end else begin
          len = $urandom_range(1, 9);
        end
      end
      send_random_msg(len);
      sent += len;
      len = 0;
    end
    drain();
  endtask

  initial begin
    sb                    = new();
    rst_ni                = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.line_breaks_on = 1'b0;
    in_if.valid           = 1'b0;
    in_if.data_byte       = '0;
    in_if.final_byte      = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: padding forms, full groups, alphabet ends
    write_breaks(1'b0);
    send_packed(64'h00, 1);
    send_packed(64'hff, 1);
    send_packed(64'h00ff, 2);
    send_packed(64'hff00, 2);
    send_packed(64'h4d616e, 3);
    send_packed(64'hfbefbf, 3);
    send_packed(64'h000000, 3);
    send_packed(64'hffffffff, 4);
    send_packed(64'h0010837f80, 5);
    drain();

    // random: first message of the first phase ends exactly on a line end
    run_phase(1'b1, 0, 0, 48, 50);
    run_phase(1'b0, 73, 0, 0, 50);
    run_phase(1'b1, 0, 73, 0, 50);
    run_phase(1'b1, 29, 29, 0, 50);

    // receiver holds off while the sender keeps offering bytes
    write_breaks(1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk_i);
    hold_cycles = 300;
    @(negedge clk_i);
    send_random_msg(17);
    send_random_msg(13);
    drain();

    $display("run covered %0d bytes in %0d messages, %0d characters checked",
             sb.bytes_seen, sb.messages_seen, sb.chars_checked);
    $display("with %0d line breaks and %0d padded groups predicted",
             sb.newlines_due, sb.padded_groups);
    if (sb.errors == 0) begin
      $display("tb_base64_stream_encoder_top passed");
    end else begin
      $display("tb_base64_stream_encoder_top failed");
    end
    $finish;
  end

endmodule
